/* hw/rtl/tllc_pkg.sv */
// Package for the two-level LRU tag lookup core: geometry defaults, codes,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
package tllc_pkg;

	localparam int unsigned L1_BYTES_DEF      = 1024;
	localparam int unsigned L1_LINE_BYTES_DEF = 32;
	localparam int unsigned L1_ASSOC_DEF      = 2;
	localparam int unsigned L2_BYTES_DEF      = 16384;
	localparam int unsigned L2_LINE_BYTES_DEF = 32;
	localparam int unsigned L2_ASSOC_DEF      = 4;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CNT_W  = 32;

	typedef enum logic [1:0] {
		OUTCOME_L1_HIT  = 2'd0,
		OUTCOME_L2_HIT  = 2'd1,
		OUTCOME_MISS    = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_L1_READ,
		ST_L1_EVAL,
		ST_L2_READ,
		ST_L2_EVAL,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch address, issue L1 set read
		logic l1_update;   // write L1 set (touch or fill)
		logic l2_read;     // issue L2 set read
		logic l2_update;   // write L2 set
		logic finish;      // update counters, drive result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic l1_hit;
		logic l2_hit;
	} dp_sts_t;

	function automatic int unsigned clog2_min1(int unsigned v);
		return (v > 1) ? $clog2(v) : 1;
	endfunction

endpackage

/* hw/rtl/tllc_level.sv */
// One tag level: set memory of tags, valid bits and LRU ranks, hit/victim logic.
// Depends on tllc_pkg.
module tllc_level #(
	parameter int unsigned BYTES      = 1024,
	parameter int unsigned LINE_BYTES = 32,
	parameter int unsigned ASSOC      = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd,
	input  logic [tllc_pkg::ADDR_W-1:0] addr,
	input  logic                        upd,
	output logic                        hit
);
	import tllc_pkg::*;

	localparam int unsigned SETS_RAW = BYTES / (LINE_BYTES * ASSOC);
	localparam int unsigned SETS   = (SETS_RAW > 0) ? SETS_RAW : 1;
	localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
	localparam int unsigned SET_W  = clog2_min1(SETS);
	localparam int unsigned SET_B  = $clog2(SETS);
	localparam int unsigned LINE_W = ADDR_W - OFF_W;
	localparam int unsigned TAG_W  = LINE_W - SET_B;
	localparam int unsigned WAY_W  = clog2_min1(ASSOC);

	logic [LINE_W-1:0] line;
	logic [SET_W-1:0]  set;
	logic [TAG_W-1:0]  tag;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;

	assign line = addr[ADDR_W-1:OFF_W];
	assign tag  = line[LINE_W-1:SET_B];
	generate
		if (SET_B > 0) begin : g_set
			assign set = line[SET_W-1:0];
		end else begin : g_noset
			assign set = '0;
		end
	endgenerate

	// one row per set: all ways side by side, read and written as a row
	logic [ASSOC-1:0][TAG_W-1:0] tag_mem [SETS];
	logic [ASSOC-1:0][WAY_W-1:0] rank_mem[SETS];
	logic [ASSOC-1:0]            val_mem [SETS];

	logic [ASSOC-1:0][TAG_W-1:0] tag_s1;
	logic [ASSOC-1:0][WAY_W-1:0] rank_s1;
	logic [ASSOC-1:0][WAY_W-1:0] rank_rd;
	logic [ASSOC-1:0]            val_rd;
	logic [ASSOC-1:0]            val_s1;
	logic                        fresh_q;

	always_ff @(posedge clk) begin
		if (rd) begin
			tag_s1  <= tag_mem[set];
			rank_rd <= rank_mem[set];
			val_rd  <= val_mem[set];
			set_q   <= set;
			tag_q   <= tag;
		end
	end

	// a row never written since reset reads as empty, ranks in way order
	logic [SETS-1:0] rank_w_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b0;
		end else if (rd) begin
			fresh_q <= !rank_w_q[set];
		end
	end

	always_comb begin
		for (int w = 0; w < ASSOC; w++) begin
			rank_s1[w] = fresh_q ? WAY_W'(w) : rank_rd[w];
		end
		val_s1 = fresh_q ? '0 : val_rd;
	end

	logic [ASSOC-1:0] match;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic             inv_found;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] pick;
	logic [ASSOC-1:0][WAY_W-1:0] rank_new;
	logic [ASSOC-1:0] val_new;

	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		for (int w = ASSOC-1; w >= 0; w--) begin
			match[w] = val_s1[w] && (tag_s1[w] == tag_q);
			if (match[w]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!val_s1[w]) begin
				inv_found = 1'b1;
				inv_way   = WAY_W'(w);
			end
			// ranks are a permutation: the oldest way holds ASSOC-1
			if (rank_s1[w] == WAY_W'(ASSOC-1)) begin
				lru_way = WAY_W'(w);
			end
		end
		pick = hit ? hit_way : (inv_found ? inv_way : lru_way);
		for (int w = 0; w < ASSOC; w++) begin
			if (WAY_W'(w) == pick) begin
				rank_new[w] = '0;
			end else if (rank_s1[w] < rank_s1[pick]) begin
				rank_new[w] = rank_s1[w] + 1'b1;
			end else begin
				rank_new[w] = rank_s1[w];
			end
		end
		val_new       = val_s1;
		val_new[pick] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			rank_mem[set_q] <= rank_new;
			val_mem[set_q]  <= val_new;
			if (!hit) begin
				tag_mem[set_q][pick] <= tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_w_q <= '0;
		end else if (upd) begin
			rank_w_q[set_q] <= 1'b1;
		end
	end

endmodule

/* hw/rtl/tllc_datapath.sv */
// Datapath: address register, both tag levels, saturating counters, result regs.
// Depends on tllc_pkg and tllc_level.
module tllc_datapath #(
	parameter int unsigned L1_BYTES      = tllc_pkg::L1_BYTES_DEF,
	parameter int unsigned L1_LINE_BYTES = tllc_pkg::L1_LINE_BYTES_DEF,
	parameter int unsigned L1_ASSOC      = tllc_pkg::L1_ASSOC_DEF,
	parameter int unsigned L2_BYTES      = tllc_pkg::L2_BYTES_DEF,
	parameter int unsigned L2_LINE_BYTES = tllc_pkg::L2_LINE_BYTES_DEF,
	parameter int unsigned L2_ASSOC      = tllc_pkg::L2_ASSOC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tllc_pkg::ADDR_W-1:0] address,
	input  tllc_pkg::dp_cmd_t           cmd,
	output tllc_pkg::dp_sts_t           sts,
	output logic                        done,
	output logic [1:0]                  outcome,
	output logic [tllc_pkg::CNT_W-1:0]  l1_hit_total,
	output logic [tllc_pkg::CNT_W-1:0]  l1_miss_total,
	output logic [tllc_pkg::CNT_W-1:0]  l2_hit_total,
	output logic [tllc_pkg::CNT_W-1:0]  l2_miss_total
);
	import tllc_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  l1h_q, l1m_q, l2h_q, l2m_q;
	logic              done_q;
	logic [1:0]        outcome_q;
	logic              l1_hit, l2_hit;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= address;
		end
	end

	tllc_level #(.BYTES(L1_BYTES), .LINE_BYTES(L1_LINE_BYTES), .ASSOC(L1_ASSOC)) u_l1 (
		.clk(clk), .arst_n(arst_n), .rd(cmd.capture), .addr(address),
		.upd(cmd.l1_update), .hit(l1_hit)
	);

	tllc_level #(.BYTES(L2_BYTES), .LINE_BYTES(L2_LINE_BYTES), .ASSOC(L2_ASSOC)) u_l2 (
		.clk(clk), .arst_n(arst_n), .rd(cmd.l2_read), .addr(addr_q),
		.upd(cmd.l2_update), .hit(l2_hit)
	);

	assign sts.l1_hit = l1_hit;
	assign sts.l2_hit = l2_hit;

	// outcome latched at the L1/L2 evaluation points
	logic [1:0] oc_q;
	always_ff @(posedge clk) begin
		if (cmd.l2_update && !l2_hit) begin
			oc_q <= OUTCOME_MISS;
		end else if (cmd.l1_update) begin
			if (l1_hit) begin
				oc_q <= OUTCOME_L1_HIT;
			end else begin
				oc_q <= OUTCOME_L2_HIT;
			end
		end
	end

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1h_q  <= '0;
			l1m_q  <= '0;
			l2h_q  <= '0;
			l2m_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				unique case (oc_q)
					OUTCOME_L1_HIT: l1h_q <= sat_inc(l1h_q);
					OUTCOME_L2_HIT: begin
						l1m_q <= sat_inc(l1m_q);
						l2h_q <= sat_inc(l2h_q);
					end
					default: begin
						l1m_q <= sat_inc(l1m_q);
						l2m_q <= sat_inc(l2m_q);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			outcome_q <= oc_q;
		end
	end

	assign done          = done_q;
	assign outcome       = outcome_q;
	assign l1_hit_total  = l1h_q;
	assign l1_miss_total = l1m_q;
	assign l2_hit_total  = l2h_q;
	assign l2_miss_total = l2m_q;

endmodule

/* hw/rtl/tllc_ctrl.sv */
// Controller state machine sequencing L1 probe, L2 probe and fills.
// Depends on tllc_pkg.
module tllc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tllc_pkg::dp_sts_t sts,
	output tllc_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import tllc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_L1_EVAL;
				end
			end
			ST_L1_EVAL: begin
				if (sts.l1_hit) begin
					cmd.l1_update = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.l2_read = 1'b1;
					state_d     = ST_L2_EVAL;
				end
			end
			ST_L2_EVAL: begin
				// L1 set row is still held; L1 fill goes with the L2 update
				cmd.l2_update = 1'b1;
				cmd.l1_update = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/two_level_lru_cache_lookup_core.sv */
// Top level of the two-level LRU tag lookup core: controller plus datapath.
// Depends on tllc_pkg, tllc_ctrl, tllc_datapath.
//
// One request (a byte address) is taken when start is high and busy is low.
// Each request runs from start to the done strobe through the L1 set read,
// an L2 set read on an L1 miss, a row write in L1 (and in L2 on a miss),
// then a counter update. busy drops in the cycle done is high, so the
// next start can be taken there; a new request waits until the last is done.
// done is high for exactly one cycle with outcome and the four saturating
// counters; the receiver cannot stall and must take the result in that cycle.
// Tags, valid bits and ranks live in per-level row memories; one written flag
// per set, cleared by reset, makes an untouched row read as empty with ranks
// in way order, so no clearing pass is needed.
module two_level_lru_cache_lookup_core #(
	parameter int unsigned L1_BYTES      = tllc_pkg::L1_BYTES_DEF,
	parameter int unsigned L1_LINE_BYTES = tllc_pkg::L1_LINE_BYTES_DEF,
	parameter int unsigned L1_ASSOC      = tllc_pkg::L1_ASSOC_DEF,
	parameter int unsigned L2_BYTES      = tllc_pkg::L2_BYTES_DEF,
	parameter int unsigned L2_LINE_BYTES = tllc_pkg::L2_LINE_BYTES_DEF,
	parameter int unsigned L2_ASSOC      = tllc_pkg::L2_ASSOC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tllc_pkg::ADDR_W-1:0] address,
	output logic                        done,
	output logic [1:0]                  outcome,
	output logic [tllc_pkg::CNT_W-1:0]  l1_hit_total,
	output logic [tllc_pkg::CNT_W-1:0]  l1_miss_total,
	output logic [tllc_pkg::CNT_W-1:0]  l2_hit_total,
	output logic [tllc_pkg::CNT_W-1:0]  l2_miss_total
);
	import tllc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tllc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	tllc_datapath #(
		.L1_BYTES(L1_BYTES), .L1_LINE_BYTES(L1_LINE_BYTES), .L1_ASSOC(L1_ASSOC),
		.L2_BYTES(L2_BYTES), .L2_LINE_BYTES(L2_LINE_BYTES), .L2_ASSOC(L2_ASSOC)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .address(address), .cmd(cmd), .sts(sts),
		.done(done), .outcome(outcome),
		.l1_hit_total(l1_hit_total), .l1_miss_total(l1_miss_total),
		.l2_hit_total(l2_hit_total), .l2_miss_total(l2_miss_total)
	);

endmodule
